### rtl/core/srtf_pkg.sv
// Shared types and constants for the SRTF tick scheduler.
`default_nettype none

package srtf_pkg;

    // Table size and time width
    localparam int MAX_JOBS  = 16;
    localparam int TIME_BITS = 16;

    // Derived widths
    localparam int IDX_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W   = $clog2(MAX_JOBS + 1);
    localparam int LABEL_W = 8;
    localparam int FIELD_T_W = 16;

    // Stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    // Saturation limit of the cycle counter
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // Operation codes carried on s_tuser
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // One job table entry, kept as one memory word
    typedef struct packed {
        logic [TIME_BITS-1:0] remaining;
        logic [TIME_BITS-1:0] arrival;
        logic [LABEL_W-1:0]   label;
    } job_entry_t;

    localparam int ENTRY_W = $bits(job_entry_t);

endpackage

`default_nettype wire

### rtl/core/srtf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/srtf_tick_scheduler_top.sv
// Top level of the shortest-remaining-time-first tick scheduler.
//
//  Channel  | Dir | Handshake          | Payload
//  ---------+-----+--------------------+--------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tuser: op; tdata: label, arrival, length
//  m_       | out | m_tvalid/m_tready  | tuser: idle, job_done, all_done;
//           |     |                    | tdata: tick_number, chosen_label, done_time
//
// A load transaction writes one table entry; a load to a full table is dropped.
// After a tick transaction s_tready stays low through the scan and the commit:
// one table read per cycle, the last read in the compare stage, the compare valid
// clearing, then the commit; a new tick is taken only once back in the idle state.
// A commit holds while the output register is still full and not being taken.
// Reset (aresetn low, synchronous) empties the table and sets the cycle counter to one.
`default_nettype none

module srtf_tick_scheduler_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input transactions
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [srtf_pkg::S_TDATA_W-1:0] s_tdata,  // job_label[7:0], arrival_time[23:8],
                                                          // job_length[39:24]
    input  wire logic                           s_tuser,  // op[0]
    // Result transactions
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [srtf_pkg::M_TDATA_W-1:0] m_tdata,  // tick_number[15:0],
                                                          // chosen_label[23:16],
                                                          // done_time[39:24]
    output logic      [srtf_pkg::M_TUSER_W-1:0] m_tuser   // idle[0], job_done[1], all_done[2]
);

    import srtf_pkg::*;

    // Input field views
    logic [LABEL_W-1:0]   in_label;
    logic [FIELD_T_W-1:0] in_arrival;
    logic [FIELD_T_W-1:0] in_length;
    op_t                  in_op;

    assign in_label   = s_tdata[7:0];
    assign in_arrival = s_tdata[23:8];
    assign in_length  = s_tdata[39:24];
    assign in_op      = op_t'(s_tuser);

    // Control state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     job_count_reg, job_count_next;
    logic [TIME_BITS-1:0] cycle_reg, cycle_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // Scan datapath
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 found_reg, found_next;
    logic                 any_left_reg, any_left_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    job_entry_t           best_reg, best_next;

    // Output payload
    logic [FIELD_T_W-1:0] tick_reg, tick_next;
    logic [LABEL_W-1:0]   label_reg, label_next;
    logic [FIELD_T_W-1:0] done_time_reg, done_time_next;
    logic                 idle_reg, idle_next;
    logic                 job_done_reg, job_done_next;
    logic                 all_done_reg, all_done_next;

    // Memory port signals
    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    job_entry_t           ram_wr_entry;
    logic                 ram_rd_en;
    logic [ENTRY_W-1:0]   ram_rd_data;
    job_entry_t           rd_entry;

    // FSM decode
    logic                 s_accept;
    logic                 out_free;
    logic                 issue_more;
    logic                 commit_go;

    // Compare and commit terms
    logic                 rd_live;
    logic                 rd_better;
    logic [TIME_BITS-1:0] rem_dec;
    logic                 pick_done;
    logic [TIME_BITS-1:0] cycle_inc;

    // Job table
    srtf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_JOBS)
    ) u_job_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign rd_entry = job_entry_t'(ram_rd_data);

    // Handshake terms
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign issue_more = issue_reg < job_count_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && in_op == OP_TICK) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue_more && !cmp_vld_reg) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready  = 1'b0;
        ram_rd_en = 1'b0;
        commit_go = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready  = 1'b1;
            ST_SCAN:   ram_rd_en = issue_more;
            ST_COMMIT: commit_go = out_free;
            default:   s_tready  = 1'b0;
        endcase
    end

    // Compare stage and commit arithmetic
    assign rd_live   = cmp_vld_reg && (rd_entry.remaining != '0);
    assign rd_better = rd_live && (rd_entry.arrival <= cycle_reg) &&
                       (!found_reg || (rd_entry.remaining < best_reg.remaining));
    assign rem_dec   = best_reg.remaining - TIME_BITS'(1);
    assign pick_done = found_reg && (rem_dec == '0);
    assign cycle_inc = (cycle_reg < TIME_MAX) ? (cycle_reg + TIME_BITS'(1)) : TIME_MAX;

    // Datapath next values
    always_comb begin
        job_count_next = job_count_reg;
        cycle_next     = cycle_reg;
        issue_next     = issue_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        any_left_next  = any_left_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        m_tvalid_next  = m_tvalid_reg;
        tick_next      = tick_reg;
        label_next     = label_reg;
        done_time_next = done_time_reg;
        idle_next      = idle_reg;
        job_done_next  = job_done_reg;
        all_done_next  = all_done_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = job_count_reg[IDX_W-1:0];
        ram_wr_entry.label     = in_label;
        ram_wr_entry.arrival   = TIME_BITS'(in_arrival);
        ram_wr_entry.remaining = TIME_BITS'(in_length);

        // Result taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Load appends a job; a full table drops it
        if (s_accept && in_op == OP_LOAD && job_count_reg < CNT_W'(MAX_JOBS)) begin
            ram_wr_en      = 1'b1;
            job_count_next = job_count_reg + CNT_W'(1);
        end

        // Tick starts a fresh scan
        if (s_accept && in_op == OP_TICK) begin
            issue_next    = '0;
            found_next    = 1'b0;
            any_left_next = 1'b0;
        end

        // Issue one read per cycle
        if (ram_rd_en) begin
            issue_next   = issue_reg + CNT_W'(1);
            cmp_vld_next = 1'b1;
            cmp_idx_next = issue_reg[IDX_W-1:0];
        end

        // Running minimum; strict compare keeps the earliest job on ties
        if (rd_live) begin
            any_left_next = 1'b1;
        end
        if (rd_better) begin
            found_next    = 1'b1;
            best_idx_next = cmp_idx_reg;
            best_next     = rd_entry;
        end

        // Commit: write back the chosen job and load the result
        if (commit_go) begin
            m_tvalid_next  = 1'b1;
            tick_next      = FIELD_T_W'(cycle_reg);
            label_next     = found_reg ? best_reg.label : '0;
            idle_next      = !found_reg;
            job_done_next  = pick_done;
            done_time_next = pick_done ? FIELD_T_W'(cycle_inc) : '0;
            all_done_next  = !any_left_reg;
            if (found_reg) begin
                ram_wr_en              = 1'b1;
                ram_wr_addr            = best_idx_reg;
                ram_wr_entry           = best_reg;
                ram_wr_entry.remaining = rem_dec;
            end
            if (any_left_reg) begin
                cycle_next = cycle_inc;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            job_count_reg <= '0;
            cycle_reg     <= TIME_BITS'(1);
            issue_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            job_count_reg <= job_count_next;
            cycle_reg     <= cycle_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmp_idx_reg   <= cmp_idx_next;
        found_reg     <= found_next;
        any_left_reg  <= any_left_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        tick_reg      <= tick_next;
        label_reg     <= label_next;
        done_time_reg <= done_time_next;
        idle_reg      <= idle_next;
        job_done_reg  <= job_done_next;
        all_done_reg  <= all_done_next;
    end

    // Result channel
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {done_time_reg, label_reg, tick_reg};
    assign m_tuser  = {all_done_reg, job_done_reg, idle_reg};

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the SRTF tick scheduler stream block.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import srtf_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_TICKS = 1050;
    localparam int RANDOM_ENTRIES = 9;
    localparam int BURST_TICKS = 150;

    // One input transaction
    typedef struct packed {
        op_t                  op;
        logic [LABEL_W-1:0]   label;
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] length;
    } job_req_t;

    // One tick report
    typedef struct packed {
        logic [TIME_BITS-1:0] tick_number;
        logic [LABEL_W-1:0]   chosen_label;
        logic                 idle;
        logic                 job_done;
        logic [TIME_BITS-1:0] done_time;
        logic                 all_done;
    } tick_report_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = OP_LOAD;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Scheduler state as predicted
    logic [LABEL_W-1:0]   tbl_label   [MAX_JOBS];
    logic [TIME_BITS-1:0] tbl_arrival [MAX_JOBS];
    logic [TIME_BITS-1:0] tbl_left    [MAX_JOBS];
    int                   jobs_loaded = 0;
    logic [TIME_BITS-1:0] clock_now = TIME_BITS'(1);

    job_req_t     pending_reqs[$];
    tick_report_t awaited_reports[$];
    job_req_t     cur_req;
    bit           no_idle = 1'b0;
    int           fail_count = 0;
    int           cycle_count = 0;

    srtf_tick_scheduler_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock and reset
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Apply one accepted transaction to the predicted state; a tick queues its report
    function automatic void run_scheduler(input job_req_t r);
        int           k;
        bit           work_left;
        bit           found;
        int           pick;
        tick_report_t rep;
        if (r.op == OP_LOAD) begin
            // full table drops the load
            if (jobs_loaded < MAX_JOBS) begin
                tbl_label[jobs_loaded]   = r.label;
                tbl_arrival[jobs_loaded] = r.arrival;
                tbl_left[jobs_loaded]    = r.length;
                jobs_loaded++;
            end
            return;
        end
        work_left = 1'b0;
        found = 1'b0;
        pick = 0;
        // least remaining time among arrived jobs, earliest entry wins a tie
        for (k = 0; k < jobs_loaded; k++) begin
            if (tbl_left[k] == 0) continue;
            work_left = 1'b1;
            if (tbl_arrival[k] > clock_now) continue;
            if (!found || tbl_left[k] < tbl_left[pick]) begin
                found = 1'b1;
                pick = k;
            end
        end
        rep = '0;
        rep.tick_number = clock_now;
        if (!work_left) begin
            // nothing left anywhere: counter holds
            rep.idle = 1'b1;
            rep.all_done = 1'b1;
        end else begin
            if (!found) begin
                rep.idle = 1'b1;
            end else begin
                tbl_left[pick] = tbl_left[pick] - 1'b1;
                rep.chosen_label = tbl_label[pick];
                if (tbl_left[pick] == 0) begin
                    rep.job_done = 1'b1;
                    rep.done_time = (clock_now < TIME_MAX) ? clock_now + 1'b1 : TIME_MAX;
                end
            end
            if (clock_now < TIME_MAX) clock_now = clock_now + 1'b1;
        end
        awaited_reports.push_back(rep);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Input driver: presents queued requests, idles at random
    always @(posedge aclk) begin : request_driver
        bit busy;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                run_scheduler(cur_req);
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 32)) begin
                    cur_req = pending_reqs.pop_front();
                    s_tdata <= {cur_req.length, cur_req.arrival, cur_req.label};
                    s_tuser <= cur_req.op;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random backpressure, compare against oldest report
    always @(posedge aclk) begin : result_monitor
        tick_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_reports.size() == 0) begin
                    $error("result transaction with no report awaited: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = awaited_reports.pop_front();
                    check_field("tick_number", want.tick_number, m_tdata[15:0]);
                    check_field("chosen_label", want.chosen_label, m_tdata[23:16]);
                    check_field("done_time", want.done_time, m_tdata[39:24]);
                    check_field("idle", want.idle, m_tuser[0]);
                    check_field("job_done", want.job_done, m_tuser[1]);
                    check_field("all_done", want.all_done, m_tuser[2]);
                end
            end
            m_tready <= no_idle || ($urandom_range(0, 99) >= 32);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[srtf_tick_scheduler_top] ERROR");
            $finish;
        end
    end

    task automatic add_load(input int lbl, input int arr, input int len);
        job_req_t r;
        r.op = OP_LOAD;
        r.label = LABEL_W'(lbl);
        r.arrival = TIME_BITS'(arr);
        r.length = TIME_BITS'(len);
        pending_reqs.push_back(r);
    endtask

    // Ticks carry random junk in the fields they ignore
    task automatic add_ticks(input int n);
        job_req_t r;
        repeat (n) begin
            r.op = OP_TICK;
            r.label = LABEL_W'($urandom);
            r.arrival = TIME_BITS'($urandom);
            r.length = TIME_BITS'($urandom);
            pending_reqs.push_back(r);
        end
    endtask

    // Hold the sender until every transaction is taken and every report is back
    task automatic wait_quiet();
        @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || awaited_reports.size() != 0)
            @(negedge aclk);
    endtask

    // Stimulus
    initial begin : stimulus
        int entries_used;
        int random_ticks;
        int budget;
        int nloads;
        int lead;
        int arr;
        int len;
        int fill;

        // Directed: empty table, zero-length job, not-yet-arrived job, tie, finishes
        add_ticks(1);
        add_load(8'h00, 0, 0);
        add_ticks(1);
        add_load(8'hFF, 3, 2);
        add_ticks(1);
        add_load(8'hA5, 0, 2);
        add_load(8'h5A, 2, 2);
        add_ticks(8);
        entries_used = 4;

        // Random groups of loads among ticks, arrivals near the current cycle
        random_ticks = 0;
        budget = RANDOM_ENTRIES;
        while (random_ticks < RANDOM_TICKS) begin
            wait_quiet();
            lead = $urandom_range(0, 3);
            add_ticks(lead);
            nloads = (budget > 0) ? $urandom_range(1, (budget < 3) ? budget : 3) : 0;
            repeat (nloads) begin
                case ($urandom_range(0, 3))
                    0: arr = 0;
                    1: arr = (clock_now > 20) ? clock_now - $urandom_range(0, 20) : 0;
                    default: arr = clock_now + lead + $urandom_range(0, 60);
                endcase
                len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 60);
                add_load($urandom_range(0, 255), arr, len);
            end
            budget -= nloads;
            entries_used += nloads;
            len = $urandom_range(80, 200);
            add_ticks(len);
            random_ticks += lead + len;
        end

        // Back-to-back stretch: longest job, late job, fill the table, then dropped loads
        wait_quiet();
        no_idle = 1'b1;
        add_load(8'h3C, 0, 16'hFFFF);
        add_load(8'h96, 16'h8000, 1);
        entries_used += 2;
        fill = MAX_JOBS - entries_used + 2;
        repeat (fill) add_load($urandom_range(0, 255), $urandom, $urandom_range(1, 5));
        add_ticks(BURST_TICKS);
        wait_quiet();
        no_idle = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[srtf_tick_scheduler_top] OK");
        end else begin
            $display("[srtf_tick_scheduler_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### srtf_tick_scheduler_top.f
rtl/core/srtf_pkg.sv
rtl/core/srtf_ram.sv
rtl/core/srtf_tick_scheduler_top.sv
sim/testbench.sv
